// ===== sv/rpq_pkg.sv =====
// rpq_pkg: shared types, codes and constants for the radar presence qualifier.
// No dependencies; imported by every module of the block.

package rpq_pkg;

    // APB address width: seven 32-bit registers at 4*i
    localparam int ADDR_W = 5;

    // Frame layout: header F4 F3 F2 F1, four skipped bytes,
    // six captured bytes, then the stationary energy byte
    localparam logic [3:0] POS_SKIP    = 4'd4;
    localparam logic [3:0] POS_CAPTURE = 4'd8;
    localparam logic [3:0] POS_LAST    = 4'd14;
    localparam int         CAP_BYTES   = 6;

    localparam logic [7:0] HDR0 = 8'hF4;
    localparam logic [7:0] HDR1 = 8'hF3;
    localparam logic [7:0] HDR2 = 8'hF2;
    localparam logic [7:0] HDR3 = 8'hF1;

    // Register reset values
    localparam logic [15:0] RST_DIST_INIT   = 16'd200;
    localparam logic [7:0]  RST_ENERGY_INIT = 8'd75;
    localparam logic [15:0] RST_HOLD        = 16'd3000;
    localparam logic [15:0] RST_CALIB_TIME  = 16'd15000;
    localparam logic [7:0]  RST_E_MARGIN    = 8'd15;
    localparam logic [7:0]  RST_E_CAP       = 8'd100;
    localparam logic [15:0] RST_D_MARGIN    = 16'd50;

    // Item kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CALIB = 1'b1;

    typedef enum logic [2:0] {
        REG_DIST_INIT   = 3'd0,
        REG_ENERGY_INIT = 3'd1,
        REG_HOLD        = 3'd2,
        REG_CALIB_TIME  = 3'd3,
        REG_E_MARGIN    = 3'd4,
        REG_E_CAP       = 3'd5,
        REG_D_MARGIN    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_VALID      = 2'd0,
        VERDICT_NO_TARGET  = 2'd1,
        VERDICT_LOW_ENERGY = 2'd2,
        VERDICT_TOO_FAR    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [15:0] dist_init;
        logic [7:0]  energy_init;
        logic [15:0] hold_ms;
        logic [15:0] calib_time_ms;
        logic [7:0]  energy_margin;
        logic [7:0]  energy_cap;
        logic [15:0] distance_margin;
    } cfg_t;

    // Write-side strobes that also reload the limits in force
    typedef struct packed {
        logic        bound;
        logic        energy;
        logic [15:0] value;
    } cfg_load_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [15:0] mdist;
        logic [7:0]  menergy;
        logic [15:0] sdist;
        logic [7:0]  senergy;
    } frame_t;

    typedef struct packed {
        logic        presence;
        logic [7:0]  target_state;
        logic [15:0] move_range;
        logic [15:0] still_range;
        logic [7:0]  peak_energy;
        verdict_t    verdict;
        logic        calibrating;
        logic [7:0]  energy_threshold;
        logic [15:0] distance_bound;
    } result_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = HDR0;
            2'd1:    b = HDR1;
            2'd2:    b = HDR2;
            default: b = HDR3;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/rpq_cfg.sv =====
// rpq_cfg: APB register file for the radar presence qualifier.
// Depends on rpq_pkg (cfg_t, cfg_load_t, register indexes).

module rpq_cfg
    import rpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg,
    output cfg_load_t         load
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    assign load.bound  = wr && (idx == REG_DIST_INIT);
    assign load.energy = wr && (idx == REG_ENERGY_INIT);
    assign load.value  = pwdata[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_init       <= RST_DIST_INIT;
            cfg_reg.energy_init     <= RST_ENERGY_INIT;
            cfg_reg.hold_ms         <= RST_HOLD;
            cfg_reg.calib_time_ms   <= RST_CALIB_TIME;
            cfg_reg.energy_margin   <= RST_E_MARGIN;
            cfg_reg.energy_cap      <= RST_E_CAP;
            cfg_reg.distance_margin <= RST_D_MARGIN;
        end
        else if (wr)
        begin
            case (idx)
                REG_DIST_INIT:   cfg_reg.dist_init       <= pwdata[15:0];
                REG_ENERGY_INIT: cfg_reg.energy_init     <= pwdata[7:0];
                REG_HOLD:        cfg_reg.hold_ms         <= pwdata[15:0];
                REG_CALIB_TIME:  cfg_reg.calib_time_ms   <= pwdata[15:0];
                REG_E_MARGIN:    cfg_reg.energy_margin   <= pwdata[7:0];
                REG_E_CAP:       cfg_reg.energy_cap      <= pwdata[7:0];
                REG_D_MARGIN:    cfg_reg.distance_margin <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DIST_INIT:   prdata = {16'd0, cfg_reg.dist_init};
            REG_ENERGY_INIT: prdata = {24'd0, cfg_reg.energy_init};
            REG_HOLD:        prdata = {16'd0, cfg_reg.hold_ms};
            REG_CALIB_TIME:  prdata = {16'd0, cfg_reg.calib_time_ms};
            REG_E_MARGIN:    prdata = {24'd0, cfg_reg.energy_margin};
            REG_E_CAP:       prdata = {24'd0, cfg_reg.energy_cap};
            REG_D_MARGIN:    prdata = {16'd0, cfg_reg.distance_margin};
            default:         prdata = 32'd0;
        endcase
    end

`ifndef ASSERT_OFF
    // an initial-limit write reloads at most one limit
    a_load_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({load.bound, load.energy}))
        else $error("rpq_cfg: both limit reloads at once");

    a_dist_write: assert property (@(posedge clk) disable iff (!rst_n)
        load.bound |=> cfg_reg.dist_init == $past(pwdata[15:0]))
        else $error("rpq_cfg: distance init not written");

    a_energy_write: assert property (@(posedge clk) disable iff (!rst_n)
        load.energy |=> cfg_reg.energy_init == $past(pwdata[7:0]))
        else $error("rpq_cfg: energy init not written");
`endif

endmodule

// ===== sv/rpq_parser.sv =====
// rpq_parser: header hunt and field capture over the radar byte stream.
// Depends on rpq_pkg (frame layout constants, frame_t, hdr_byte).

module rpq_parser
    import rpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic       kind,
    input  logic [7:0] radar_byte,
    output logic       frame_last,
    output frame_t     frame
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] cap_reg [CAP_BYTES];
    logic [2:0] cap_idx;
    logic       take;

    assign take       = go && (kind == KIND_BYTE);
    assign cap_idx    = 3'(pos_reg - POS_CAPTURE);
    assign frame_last = (pos_reg == POS_LAST);

    always_comb
    begin
        if (pos_reg < POS_SKIP)
        begin
            if (radar_byte == hdr_byte(pos_reg[1:0]))
                pos_next = pos_reg + 4'd1;
            else if (radar_byte == HDR0)
                pos_next = 4'd1;
            else
                pos_next = 4'd0;
        end
        else if (frame_last)
            pos_next = 4'd0;
        else
            pos_next = pos_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 4'd0;
        else if (take)
            pos_reg <= pos_next;
    end

    // captured bytes are always rewritten before the frame end reads them
    always_ff @(posedge clk)
    begin
        if (take && pos_reg >= POS_CAPTURE && !frame_last)
            cap_reg[cap_idx] <= radar_byte;
    end

    assign frame.status  = cap_reg[0];
    assign frame.mdist   = {cap_reg[2], cap_reg[1]};
    assign frame.menergy = cap_reg[3];
    assign frame.sdist   = {cap_reg[5], cap_reg[4]};
    assign frame.senergy = radar_byte;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("rpq_parser: frame position out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_last |=> pos_reg == 4'd0)
        else $error("rpq_parser: no restart after frame end");

    a_calib_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        go && kind == KIND_CALIB |=> $stable(pos_reg))
        else $error("rpq_parser: calibration command moved parser");
`endif

endmodule

// ===== sv/rpq_qualifier.sv =====
// rpq_qualifier: calibration, thresholds, filter verdict and presence hold.
// Depends on rpq_pkg (cfg_t, cfg_load_t, frame_t, result_t, verdict codes).

module rpq_qualifier
    import rpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic        kind,
    input  logic [31:0] now_ms,
    input  logic        frame_last,
    input  frame_t      frame,
    input  cfg_t        cfg,
    input  cfg_load_t   load,
    output logic        res_valid,
    output result_t     result
);

    logic [7:0]  thr_reg,        thr_next;
    logic [15:0] bound_reg,      bound_next;
    logic        cal_active_reg, cal_active_next;
    logic [31:0] cal_end_reg,    cal_end_next;
    logic [7:0]  max_e_reg,      max_e_next;
    logic [15:0] max_d_reg,      max_d_next;
    logic [31:0] last_valid_reg, last_valid_next;
    logic        presence_reg,   presence_next;

    logic        is_calib, is_frame;
    logic [7:0]  peak;
    logic [15:0] prim;
    logic [31:0] diff;
    logic        in_window, cal_end;
    logic [8:0]  e_sum;
    logic [7:0]  e_sat;
    logic [16:0] d_sum;
    logic [15:0] d_sat;
    logic [7:0]  thr_eff;
    logic [15:0] bound_eff;
    verdict_t    verdict;
    logic [31:0] elapsed;

    assign is_calib = go && (kind == KIND_CALIB);
    assign is_frame = go && (kind == KIND_BYTE) && frame_last;

    always_comb
    begin
        peak = (frame.menergy > frame.senergy) ? frame.menergy : frame.senergy;
        prim = (frame.status inside {8'd1, 8'd3}) ? frame.mdist : frame.sdist;

        diff      = cal_end_reg - now_ms;
        in_window = (diff != 32'd0) && !diff[31];
        cal_end   = cal_active_reg && !in_window;

        // saturating limit update; cap never exceeds 255 so it bounds e too
        e_sum = {1'b0, max_e_reg} + {1'b0, cfg.energy_margin};
        e_sat = (e_sum > {1'b0, cfg.energy_cap}) ? cfg.energy_cap : e_sum[7:0];
        d_sum = {1'b0, max_d_reg} + {1'b0, cfg.distance_margin};
        d_sat = d_sum[16] ? 16'hFFFF : d_sum[15:0];

        thr_eff   = cal_end ? e_sat : thr_reg;
        bound_eff = cal_end ? d_sat : bound_reg;

        if (frame.status == 8'd0)
            verdict = VERDICT_NO_TARGET;
        else if (peak < thr_eff)
            verdict = VERDICT_LOW_ENERGY;
        else if (prim > bound_eff)
            verdict = VERDICT_TOO_FAR;
        else
            verdict = VERDICT_VALID;

        elapsed = now_ms - last_valid_reg;
    end

    always_comb
    begin
        thr_next        = thr_reg;
        bound_next      = bound_reg;
        cal_active_next = cal_active_reg;
        cal_end_next    = cal_end_reg;
        max_e_next      = max_e_reg;
        max_d_next      = max_d_reg;
        last_valid_next = last_valid_reg;
        presence_next   = presence_reg;

        if (load.bound)
            bound_next = load.value;
        if (load.energy)
            thr_next = load.value[7:0];

        if (is_calib)
        begin
            max_e_next      = 8'd0;
            max_d_next      = 16'd0;
            cal_active_next = 1'b1;
            cal_end_next    = now_ms + {16'd0, cfg.calib_time_ms};
        end
        else if (is_frame)
        begin
            if (cal_active_reg && in_window)
            begin
                if (peak > max_e_reg)
                    max_e_next = peak;
                if (prim > max_d_reg)
                    max_d_next = prim;
            end
            else if (cal_end)
            begin
                cal_active_next = 1'b0;
                thr_next        = e_sat;
                bound_next      = d_sat;
            end

            if (verdict == VERDICT_VALID)
            begin
                last_valid_next = now_ms;
                presence_next   = 1'b1;
            end
            else if (elapsed > {16'd0, cfg.hold_ms})
                presence_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= RST_ENERGY_INIT;
            bound_reg      <= RST_DIST_INIT;
            cal_active_reg <= 1'b0;
            cal_end_reg    <= 32'd0;
            max_e_reg      <= 8'd0;
            max_d_reg      <= 16'd0;
            last_valid_reg <= 32'd0;
            presence_reg   <= 1'b0;
        end
        else
        begin
            thr_reg        <= thr_next;
            bound_reg      <= bound_next;
            cal_active_reg <= cal_active_next;
            cal_end_reg    <= cal_end_next;
            max_e_reg      <= max_e_next;
            max_d_reg      <= max_d_next;
            last_valid_reg <= last_valid_next;
            presence_reg   <= presence_next;
        end
    end

    assign res_valid               = is_frame;
    assign result.presence         = presence_next;
    assign result.target_state     = frame.status;
    assign result.move_range       = frame.mdist;
    assign result.still_range      = frame.sdist;
    assign result.peak_energy      = peak;
    assign result.verdict          = verdict;
    assign result.calibrating      = cal_active_next;
    assign result.energy_threshold = thr_eff;
    assign result.distance_bound   = bound_eff;

`ifndef ASSERT_OFF
    a_cal_close: assert property (@(posedge clk) disable iff (!rst_n)
        is_frame && cal_end |=> !cal_active_reg)
        else $error("rpq_qualifier: window not closed");

    a_thr_capped: assert property (@(posedge clk) disable iff (!rst_n)
        is_frame && cal_end |=> thr_reg <= $past(cfg.energy_cap))
        else $error("rpq_qualifier: calibrated threshold above cap");

    a_valid_marks: assert property (@(posedge clk) disable iff (!rst_n)
        is_frame && verdict == VERDICT_VALID
            |=> presence_reg && last_valid_reg == $past(now_ms))
        else $error("rpq_qualifier: valid detection not recorded");

    a_calib_start: assert property (@(posedge clk) disable iff (!rst_n)
        is_calib |=> cal_active_reg && max_e_reg == 8'd0 && max_d_reg == 16'd0)
        else $error("rpq_qualifier: calibration start not applied");
`endif

endmodule

// ===== sv/radar_presence_qualifier_top.sv =====
// radar_presence_qualifier_top: top level, input and result registers.
// Depends on rpq_pkg, rpq_cfg, rpq_parser and rpq_qualifier.
//
// Usage:
//   Input channel (in_valid/in_stall): one beat per item. kind 0 carries one
//   radar UART byte with its millisecond timestamp now_ms; kind 1 starts a
//   calibration window of calibration_time_ms from now_ms.
//   Output channel (out_valid/out_stall): one beat per complete radar frame,
//   on the frame's last byte; header bytes, skipped bytes, captured bytes and
//   calibration commands give no beat.
//   Path: an accepted item waits in the input register, is parsed and qualified
//   from there, and its result beat is loaded into the result register.
//   Throughput: one item per cycle unless stalled. The input register feeds
//   the parser and qualifier, whose single pass of compare/add logic ends in
//   the result register, so the two sides are parted by one register each.
//   Stall: while a result waits in the result register and out_stall is high,
//   the item in the input register waits and in_stall rises; nothing is lost.
//   Reset (rst_n low, async): parser back to header hunt, calibration idle,
//   presence cleared, registers and limits in force to their reset values.
//   Configuration: APB, register i at byte address 4*i; the user must write it
//   only while idle, which the block does not enforce; pready is always high.

module radar_presence_qualifier_top
    import rpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [7:0]        radar_byte,
    input  logic [31:0]       now_ms,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              presence,
    output logic [7:0]        target_state,
    output logic [15:0]       move_range,
    output logic [15:0]       still_range,
    output logic [7:0]        peak_energy,
    output logic [1:0]        verdict,
    output logic              calibrating,
    output logic [7:0]        energy_threshold,
    output logic [15:0]       distance_bound,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // input register
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [7:0]  s1_byte_reg;
    logic [31:0] s1_now_reg;
    logic        s1_go;

    // result register
    logic        out_valid_reg;
    result_t     out_reg;

    cfg_t        cfg;
    cfg_load_t   load;
    frame_t      frame;
    logic        frame_last;
    logic        res_valid;
    result_t     result;

    // the held item moves on unless a finished result is still stalled
    assign s1_go    = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg <= kind;
            s1_byte_reg <= radar_byte;
            s1_now_reg  <= now_ms;
        end
    end

    rpq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .load    (load)
    );

    rpq_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (s1_go),
        .kind       (s1_kind_reg),
        .radar_byte (s1_byte_reg),
        .frame_last (frame_last),
        .frame      (frame)
    );

    rpq_qualifier u_qual (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (s1_go),
        .kind       (s1_kind_reg),
        .now_ms     (s1_now_reg),
        .frame_last (frame_last),
        .frame      (frame),
        .cfg        (cfg),
        .load       (load),
        .res_valid  (res_valid),
        .result     (result)
    );

    // result beat: loaded on a frame end, dropped once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= result;
    end

    assign out_valid        = out_valid_reg;
    assign presence         = out_reg.presence;
    assign target_state     = out_reg.target_state;
    assign move_range       = out_reg.move_range;
    assign still_range      = out_reg.still_range;
    assign peak_energy      = out_reg.peak_energy;
    assign verdict          = out_reg.verdict;
    assign calibrating      = out_reg.calibrating;
    assign energy_threshold = out_reg.energy_threshold;
    assign distance_bound   = out_reg.distance_bound;

`ifndef ASSERT_OFF
    // a new result never lands on one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !res_valid)
        else $error("top: result overwritten while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("top: input stalled without a stalled result");

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_now_reg) && $stable(s1_byte_reg))
        else $error("top: held item lost");
`endif

endmodule
